// ===== sv/tpp_pkg.sv =====
// shared types and constants for the touch packet parser
`timescale 1ns / 1ps

package tpp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COORD_W = 12;
  localparam int unsigned LOW_W   = 7;
  localparam int unsigned HIGH_W  = 5;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE_SYNC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PEN_UP        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PEN_DOWN      = 2'd2;

  localparam logic [BYTE_W-1:0] RESPONSE_SYNC_RST = 8'h55;
  localparam logic [BYTE_W-1:0] PEN_UP_RST        = 8'h80;
  localparam logic [BYTE_W-1:0] PEN_DOWN_RST      = 8'h81;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_LEN  = 3'd1,
    PH_BODY = 3'd2,
    PH_PEN0 = 3'd3,
    PH_PEN1 = 3'd4,
    PH_PEN2 = 3'd5,
    PH_PEN3 = 3'd6
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PEN_DOWN = 3'd0,
    KIND_PEN_UP   = 3'd1,
    KIND_BODY     = 3'd2,
    KIND_BAD_SYNC = 3'd3,
    KIND_EMPTY    = 3'd4
  } kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0] response_sync_code;
    logic [BYTE_W-1:0] pen_up_code;
    logic [BYTE_W-1:0] pen_down_code;
  } cfg_t;

  typedef struct packed {
    logic               vld;
    kind_t              event_kind;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [BYTE_W-1:0]  body_data;
    logic [BYTE_W-1:0]  body_length;
    logic               body_last;
  } result_t;

  typedef struct packed {
    phase_t phase;
  } status_t;

endpackage

// ===== sv/tpp_if.sv =====
// item channel interfaces for received bytes and parsed events
`timescale 1ns / 1ps

interface tpp_byte_if
  import tpp_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tpp_event_if
  import tpp_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  event_kind;
  logic [COORD_W-1:0] pos_x;
  logic [COORD_W-1:0] pos_y;
  logic [BYTE_W-1:0]  body_data;
  logic [BYTE_W-1:0]  body_length;
  logic               body_last;

  modport source (output valid, output event_kind, output pos_x, output pos_y,
                  output body_data, output body_length, output body_last,
                  input ready);
  modport sink   (input valid, input event_kind, input pos_x, input pos_y,
                  input body_data, input body_length, input body_last,
                  output ready);
endinterface

// ===== sv/tpp_cfg.sv =====
// lead byte code registers
`timescale 1ns / 1ps

module tpp_cfg
  import tpp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_RESPONSE_SYNC: cfg_nxt.response_sync_code = cfg_wdata;
        CFG_PEN_UP:        cfg_nxt.pen_up_code        = cfg_wdata;
        CFG_PEN_DOWN:      cfg_nxt.pen_down_code      = cfg_wdata;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.response_sync_code <= RESPONSE_SYNC_RST;
      cfg_r.pen_up_code        <= PEN_UP_RST;
      cfg_r.pen_down_code      <= PEN_DOWN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/tpp_fsm.sv =====
// packet framing state machine and result formation
`timescale 1ns / 1ps

module tpp_fsm
  import tpp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [BYTE_W-1:0] rx_byte,
  input  cfg_t              cfg,
  output result_t           res,
  output status_t           status
);

  phase_t             phase_r, phase_nxt;
  logic               pen_is_up_r, pen_is_up_nxt;
  logic [BYTE_W-1:0]  bytes_left_r, bytes_left_nxt;
  logic [BYTE_W-1:0]  frame_length_r, frame_length_nxt;
  logic [COORD_W-1:0] partial_x_r, partial_x_nxt;
  logic [LOW_W-1:0]   partial_y_low_r, partial_y_low_nxt;

  logic hit_sync, hit_up, hit_down;

  assign hit_sync = (rx_byte == cfg.response_sync_code);
  assign hit_up   = (rx_byte == cfg.pen_up_code);
  assign hit_down = (rx_byte == cfg.pen_down_code);

  // next state
  always_comb begin
    phase_nxt         = phase_r;
    pen_is_up_nxt     = pen_is_up_r;
    bytes_left_nxt    = bytes_left_r;
    frame_length_nxt  = frame_length_r;
    partial_x_nxt     = partial_x_r;
    partial_y_low_nxt = partial_y_low_r;
    case (phase_r)
      PH_LEN: begin
        frame_length_nxt = rx_byte;
        bytes_left_nxt   = rx_byte;
        phase_nxt        = (rx_byte == '0) ? PH_HUNT : PH_BODY;
      end
      PH_BODY: begin
        bytes_left_nxt = bytes_left_r - BYTE_W'(1);
        if (bytes_left_r == BYTE_W'(1)) phase_nxt = PH_HUNT;
      end
      PH_PEN0: begin
        partial_x_nxt = {{HIGH_W{1'b0}}, rx_byte[LOW_W-1:0]};
        phase_nxt     = PH_PEN1;
      end
      PH_PEN1: begin
        partial_x_nxt = {rx_byte[HIGH_W-1:0], partial_x_r[LOW_W-1:0]};
        phase_nxt     = PH_PEN2;
      end
      PH_PEN2: begin
        partial_y_low_nxt = rx_byte[LOW_W-1:0];
        phase_nxt         = PH_PEN3;
      end
      PH_PEN3: begin
        phase_nxt = PH_HUNT;
      end
      default: begin
        phase_nxt = PH_HUNT;
        if (hit_sync) begin
          phase_nxt = PH_LEN;
        end else if (hit_up || hit_down) begin
          pen_is_up_nxt = hit_up;
          phase_nxt     = PH_PEN0;
        end
      end
    endcase
  end

  // result for the byte on offer
  always_comb begin
    res = '0;
    res.event_kind = KIND_PEN_DOWN;
    case (phase_r)
      PH_LEN: begin
        if (rx_byte == '0) begin
          res.vld        = 1'b1;
          res.event_kind = KIND_EMPTY;
        end
      end
      PH_BODY: begin
        res.vld         = 1'b1;
        res.event_kind  = KIND_BODY;
        res.body_data   = rx_byte;
        res.body_length = frame_length_r;
        res.body_last   = (bytes_left_r == BYTE_W'(1));
      end
      PH_PEN0, PH_PEN1, PH_PEN2: begin
        res.vld = 1'b0;
      end
      PH_PEN3: begin
        res.vld        = 1'b1;
        res.event_kind = pen_is_up_r ? KIND_PEN_UP : KIND_PEN_DOWN;
        res.pos_x      = partial_x_r;
        res.pos_y      = {rx_byte[HIGH_W-1:0], partial_y_low_r};
      end
      default: begin
        if (!hit_sync && !hit_up && !hit_down) begin
          res.vld        = 1'b1;
          res.event_kind = KIND_BAD_SYNC;
          res.body_data  = rx_byte;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_HUNT;
      pen_is_up_r     <= 1'b0;
      bytes_left_r    <= '0;
      frame_length_r  <= '0;
      partial_x_r     <= '0;
      partial_y_low_r <= '0;
    end else if (take) begin
      phase_r         <= phase_nxt;
      pen_is_up_r     <= pen_is_up_nxt;
      bytes_left_r    <= bytes_left_nxt;
      frame_length_r  <= frame_length_nxt;
      partial_x_r     <= partial_x_nxt;
      partial_y_low_r <= partial_y_low_nxt;
    end
  end

  assign status.phase = phase_r;

endmodule

// ===== sv/tpp_out_reg.sv =====
// result register between the parser and the event channel
`timescale 1ns / 1ps

module tpp_out_reg
  import tpp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    take,
  input  result_t res,
  input  logic    out_ready,
  output logic    in_ready,
  output logic    out_valid,
  output result_t out_res
);

  logic    valid_r, valid_nxt;
  result_t data_r;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) valid_nxt = take && res.vld;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res.vld) data_r <= res;
  end

  assign out_valid = valid_r;
  assign out_res   = data_r;

endmodule

// ===== sv/touch_packet_parser.sv =====
// top level of the touch controller byte stream parser
`timescale 1ns / 1ps

// takes one received byte per item and frames the touch controller stream:
// a response-sync lead byte opens a length byte and that many body bytes,
// each passed out with the length and a last flag (zero length gives an
// empty-message event); a pen-up or pen-down lead byte opens four bytes that
// build 12-bit x and y, reported as one pen event; any other lead byte gives
// a bad-sync event. a byte is taken every cycle as long as the result register
// is free or being emptied in that cycle, so the sustained rate is one item
// per clock; an event is on the output in the cycle after its last byte. the
// user must set lead byte codes via cfg port while idle, the block won't check

module touch_packet_parser
  import tpp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  tpp_byte_if.sink             in_ch,
  tpp_event_if.source          out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata
);

  cfg_t    cfg;
  result_t res;
  result_t out_res;
  status_t status;
  logic    take;
  logic    in_ready;
  logic    out_valid;

  // item accepted when both sides agree
  assign take        = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  tpp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // framing state and combinational result for the byte on offer
  tpp_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .rx_byte (in_ch.rx_byte),
    .cfg     (cfg),
    .res     (res),
    .status  (status)
  );

  // result register, frees itself in the same cycle it is read
  tpp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .res       (res),
    .out_ready (out_ch.ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_ch.valid       = out_valid;
  assign out_ch.event_kind  = out_res.event_kind;
  assign out_ch.pos_x       = out_res.pos_x;
  assign out_ch.pos_y       = out_res.pos_y;
  assign out_ch.body_data   = out_res.body_data;
  assign out_ch.body_length = out_res.body_length;
  assign out_ch.body_last   = out_res.body_last;

`ifndef NO_ASSERTIONS
  // last coordinate byte always yields a pen event next cycle
  a_pen_event: assert property (@(posedge clk) disable iff (!rst_n)
    take && (status.phase == PH_PEN3) |=> out_valid &&
      ((out_ch.event_kind == KIND_PEN_UP) || (out_ch.event_kind == KIND_PEN_DOWN)))
    else $error("pen packet end did not give a pen event");

  // an unknown lead byte is reported with its value
  a_bad_sync: assert property (@(posedge clk) disable iff (!rst_n)
    take && (status.phase == PH_HUNT) &&
      (in_ch.rx_byte != cfg.response_sync_code) &&
      (in_ch.rx_byte != cfg.pen_up_code) && (in_ch.rx_byte != cfg.pen_down_code)
      |=> out_valid && (out_ch.event_kind == KIND_BAD_SYNC) &&
      (out_ch.body_data == $past(in_ch.rx_byte)))
    else $error("bad lead byte not reported");

  // body items always carry a non-zero length
  a_body_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_ch.event_kind == KIND_BODY) |-> (out_ch.body_length != '0))
    else $error("body item with zero length");
`endif

endmodule

// ===== tb/tb_touch_packet_parser.sv =====
// self-checking testbench for the touch controller byte stream parser
`timescale 1ns / 1ps

module tb_touch_packet_parser;
  import tpp_pkg::*;

  // run limit in clock cycles, well above the slowest legal run
  localparam int CYCLE_LIMIT = 800_000;
  // cycles allowed after the last event before the parser counts as idle
  localparam int SETTLE_CYCLES = 4;
  // receiver hold-off used to back the parser up
  localparam int LONG_HOLD = 300;
  // register index the parser does not decode
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  // one parsed event as seen on the output channel
  typedef struct packed {
    kind_t              kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [BYTE_W-1:0]  data;
    logic [BYTE_W-1:0]  len;
    logic               last;
  } touch_event_t;

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_wdata;

  tpp_byte_if  byte_ch ();
  tpp_event_if event_ch ();

  touch_packet_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (byte_ch),
    .out_ch    (event_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // shadow of the parser: lead byte codes and framing state
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0]  sync_code_q;
  logic [BYTE_W-1:0]  up_code_q;
  logic [BYTE_W-1:0]  down_code_q;
  phase_t             frame_phase;
  logic               pen_up_pkt;
  logic [BYTE_W-1:0]  body_remaining;
  logic [BYTE_W-1:0]  msg_len;
  logic [COORD_W-1:0] acc_x;
  logic [LOW_W-1:0]   acc_y_low;

  // events still owed by the parser, oldest first
  touch_event_t pending_events[$];

  int  error_count;
  int  bytes_accepted;
  int  cycle_count;
  int  sink_hold_cycles;
  bit  steady_flow;

  // ---------------------------------------------------------------------------
  // clock and watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  // gap lengths: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // message lengths: mostly short, sometimes empty, rarely the full 255
  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return 255;
    if (r < 10) return 0;
    return $urandom_range(1, 12);
  endfunction

  task automatic push_event(input kind_t kind, input logic [COORD_W-1:0] x,
                            input logic [COORD_W-1:0] y, input logic [BYTE_W-1:0] data,
                            input logic [BYTE_W-1:0] len, input logic last);
    touch_event_t ev;
    ev.kind = kind;
    ev.x    = x;
    ev.y    = y;
    ev.data = data;
    ev.len  = len;
    ev.last = last;
    pending_events.push_back(ev);
  endtask

  // advances the shadow framer by one accepted byte and queues any event it owes
  task automatic track_stream_byte(input logic [BYTE_W-1:0] b);
    case (frame_phase)
      PH_LEN: begin
        msg_len        = b;
        body_remaining = b;
        if (b == '0) begin
          // empty message: kind only, all other fields zero
          frame_phase = PH_HUNT;
          push_event(KIND_EMPTY, '0, '0, '0, '0, 1'b0);
        end else begin
          frame_phase = PH_BODY;
        end
      end
      PH_BODY: begin
        body_remaining = body_remaining - 1'b1;
        push_event(KIND_BODY, '0, '0, b, msg_len, body_remaining == '0);
        if (body_remaining == '0) frame_phase = PH_HUNT;
      end
      PH_PEN0: begin
        acc_x       = {{HIGH_W{1'b0}}, b[LOW_W-1:0]};
        frame_phase = PH_PEN1;
      end
      PH_PEN1: begin
        acc_x       = {b[HIGH_W-1:0], acc_x[LOW_W-1:0]};
        frame_phase = PH_PEN2;
      end
      PH_PEN2: begin
        acc_y_low   = b[LOW_W-1:0];
        frame_phase = PH_PEN3;
      end
      PH_PEN3: begin
        frame_phase = PH_HUNT;
        push_event(pen_up_pkt ? KIND_PEN_UP : KIND_PEN_DOWN, acc_x,
                   {b[HIGH_W-1:0], acc_y_low}, '0, '0, 1'b0);
      end
      default: begin
        // lead byte: sync wins over pen up, pen up over pen down
        frame_phase = PH_HUNT;
        if (b == sync_code_q) begin
          frame_phase = PH_LEN;
        end else if (b == up_code_q || b == down_code_q) begin
          pen_up_pkt  = (b == up_code_q);
          frame_phase = PH_PEN0;
        end else begin
          push_event(KIND_BAD_SYNC, '0, '0, b, '0, 1'b0);
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // event receiver: random back-pressure, long hold-off on request, checking
  // ---------------------------------------------------------------------------
  task automatic check_event();
    touch_event_t want;
    touch_event_t got;
    string        want_s;
    string        got_s;
    got.kind = kind_t'(event_ch.event_kind);
    got.x    = event_ch.pos_x;
    got.y    = event_ch.pos_y;
    got.data = event_ch.body_data;
    got.len  = event_ch.body_length;
    got.last = event_ch.body_last;
    got_s = $sformatf("kind %0d x %0d y %0d data %02h len %0d last %0b",
                      got.kind, got.x, got.y, got.data, got.len, got.last);
    if (pending_events.size() == 0) begin
      error_count++;
      $display("%0t: unexpected event, expected none, got %s", $realtime, got_s);
      return;
    end
    want = pending_events.pop_front();
    if (got.kind !== want.kind || got.x !== want.x || got.y !== want.y ||
        got.data !== want.data || got.len !== want.len || got.last !== want.last) begin
      error_count++;
      want_s = $sformatf("kind %0d x %0d y %0d data %02h len %0d last %0b",
                         want.kind, want.x, want.y, want.data, want.len, want.last);
      $display("%0t: event mismatch, expected %s, got %s", $realtime, want_s, got_s);
    end
  endtask

  initial begin : event_sink
    int stall_left;
    stall_left = 0;
    event_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && event_ch.valid && event_ch.ready) check_event();
      if (sink_hold_cycles > 0) begin
        // long hold-off, counted here so the sender keeps pushing meanwhile
        sink_hold_cycles--;
        event_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        event_ch.ready <= 1'b0;
      end else begin
        event_ch.ready <= 1'b1;
        stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // byte sender and configuration writes
  // ---------------------------------------------------------------------------

  // offers one byte after a random gap; valid stays high into the next item
  task automatic send_byte(input logic [BYTE_W-1:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.rx_byte <= value;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    track_stream_byte(value);
    bytes_accepted++;
  endtask

  // sender pauses until every owed event is out, then lets the pipe settle
  task automatic wait_for_events();
    byte_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_events.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      CFG_RESPONSE_SYNC: sync_code_q = value;
      CFG_PEN_UP:        up_code_q   = value;
      CFG_PEN_DOWN:      down_code_q = value;
      default: ;
    endcase
  endtask

  // writes all three lead codes plus junk to the undecoded index once no event is owed
  task automatic program_codes(input logic [BYTE_W-1:0] sync_v,
                               input logic [BYTE_W-1:0] up_v,
                               input logic [BYTE_W-1:0] down_v);
    wait_for_events();
    write_reg(CFG_RESPONSE_SYNC, sync_v);
    write_reg(CFG_PEN_UP, up_v);
    write_reg(CFG_PEN_DOWN, down_v);
    write_reg(CFG_UNUSED_IDX, 8'($urandom_range(0, 255)));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_reset();
    rst_n           <= 1'b0;
    byte_ch.valid   <= 1'b0;
    byte_ch.rx_byte <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_wdata       <= '0;
    sync_code_q    = RESPONSE_SYNC_RST;
    up_code_q      = PEN_UP_RST;
    down_code_q    = PEN_DOWN_RST;
    frame_phase    = PH_HUNT;
    pen_up_pkt     = 1'b0;
    body_remaining = '0;
    msg_len        = '0;
    acc_x          = '0;
    acc_y_low      = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  endtask

  // one packet with random content; some truncated, some plain noise bytes
  task automatic send_random_packet();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      send_byte($urandom_range(0, 1) ? up_code_q : down_code_q);
      repeat (4) send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 70) begin
      len = pick_length();
      send_byte(sync_code_q);
      send_byte(8'(len));
      repeat (len) send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 80) begin
      // cut-off packet: the next lead byte lands inside it
      case ($urandom_range(0, 2))
        0:       send_byte(sync_code_q);
        1:       send_byte(up_code_q);
        default: send_byte(down_code_q);
      endcase
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // field extremes, each packet type and the empty message at reset codes
  task automatic test_reset_codes();
    send_byte(8'h00);                    // bad sync, low extreme
    send_byte(8'hFF);                    // bad sync, high extreme
    send_byte(PEN_DOWN_RST);             // pen down, all coordinate bits set
    repeat (4) send_byte(8'hFF);
    send_byte(PEN_UP_RST);               // pen up, all coordinate bits clear
    repeat (4) send_byte(8'h00);
    send_byte(RESPONSE_SYNC_RST);        // empty message
    send_byte(8'h00);
    send_byte(RESPONSE_SYNC_RST);        // single byte body
    send_byte(8'h01);
    send_byte(8'hAB);
    send_byte(RESPONSE_SYNC_RST);        // two byte body at the extremes
    send_byte(8'h02);
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  // codes that coincide: sync beats pen up, pen up beats pen down
  task automatic test_coinciding_codes();
    program_codes(8'h40, 8'h40, 8'h40);
    send_byte(8'h40);
    send_byte(8'h02);
    send_byte(8'h11);
    send_byte(8'h22);
    program_codes(RESPONSE_SYNC_RST, 8'h90, 8'h90);
    send_byte(8'h90);
    repeat (4) send_byte(8'($urandom_range(0, 255)));
    program_codes(8'hA0, PEN_UP_RST, 8'hA0);
    send_byte(8'hA0);
    send_byte(8'h00);
  endtask

  // register writes in mid-packet only count from the next lead byte
  task automatic test_mid_packet_writes();
    program_codes(RESPONSE_SYNC_RST, PEN_UP_RST, PEN_DOWN_RST);
    send_byte(PEN_DOWN_RST);
    send_byte(8'h7F);
    program_codes(RESPONSE_SYNC_RST, PEN_DOWN_RST, PEN_UP_RST);  // swap pen codes
    send_byte(8'h1F);
    send_byte(8'h00);
    send_byte(8'h1F);                    // still a pen down event
    send_byte(RESPONSE_SYNC_RST);
    send_byte(8'h03);
    send_byte(8'hA5);
    program_codes(8'h3C, PEN_DOWN_RST, PEN_UP_RST);              // move sync code
    send_byte(8'h5A);
    send_byte(8'hC3);                    // body runs to its end regardless
    send_byte(RESPONSE_SYNC_RST);        // old sync code is now a bad lead byte
    send_byte(8'h3C);
    send_byte(8'h00);
  endtask

  task automatic test_random_stream(input int n_items);
    int stop_at;
    stop_at = bytes_accepted + n_items;
    while (bytes_accepted < stop_at) send_random_packet();
  endtask

  // receiver holds off long enough for the parser to stall its input
  task automatic test_output_stall();
    wait_for_events();
    steady_flow      = 1'b1;
    sink_hold_cycles = LONG_HOLD;
    test_random_stream(40);
    steady_flow = 1'b0;
    wait_for_events();
  endtask

  task automatic program_random_codes();
    logic [BYTE_W-1:0] s, u, d;
    do begin
      s = 8'($urandom_range(0, 255));
      u = 8'($urandom_range(0, 255));
      d = 8'($urandom_range(0, 255));
    end while (s == u || s == d || u == d);
    program_codes(s, u, d);
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    error_count      = 0;
    bytes_accepted   = 0;
    sink_hold_cycles = 0;
    steady_flow      = 1'b0;

    apply_reset();
    test_reset_codes();
    test_coinciding_codes();
    test_mid_packet_writes();

    program_codes(RESPONSE_SYNC_RST, PEN_UP_RST, PEN_DOWN_RST);
    test_random_stream(350);
    program_codes(8'h00, 8'hFF, 8'h7F);
    test_random_stream(300);
    test_output_stall();
    program_codes(8'hFF, 8'h00, 8'h01);
    steady_flow = 1'b1;                  // a stretch with no idling on either side
    test_random_stream(250);
    steady_flow = 1'b0;
    program_random_codes();
    test_random_stream(330);

    wait_for_events();
    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
